// ===== rtl/core/gl3_pkg.sv =====
// Shared types and constants of the 3x3 Gaussian low-pass filter.
// No dependencies; the front end, back end and top level import this package.
package gl3_pkg;

  localparam int unsigned MaxWidthDefault  = 1024;
  localparam int unsigned PixelBitsDefault = 16;

  localparam int unsigned WidthRegBits  = 11;
  localparam int unsigned HeightRegBits = 16;
  localparam int unsigned CfgDataBits   = 16;
  localparam int unsigned OutBits       = 13;

  localparam logic [WidthRegBits-1:0]  WidthReset  = 11'd640;
  localparam logic [HeightRegBits-1:0] HeightReset = 16'd480;

  // configuration register indexes
  localparam logic CfgImageWidth  = 1'b0;
  localparam logic CfgImageHeight = 1'b1;

  // input operation codes
  localparam logic OpPixel = 1'b0;
  localparam logic OpFlush = 1'b1;

  // 160 = 2^KernelShift * KernelOdd
  localparam int unsigned KernelShift = 5;
  localparam int unsigned KernelOdd   = 5;

  localparam int unsigned ItemQueueDepth = 4;
  localparam int unsigned OutQueueDepth  = 8;

  // per-item border classification, decided from the stream counters
  typedef struct packed {
    logic emit;
    logic mask_left;
    logic mask_top;
    logic mask_bot;
    logic right_zero;
    logic last;
  } cls_t;

  typedef struct packed {
    logic [OutBits-1:0] pixel;
    logic               last;
  } result_t;

endpackage

// ===== rtl/core/gl3_fifo.sv =====
// Small register FIFO used for the item queue and the result queue.
// Depth must be a power of two. No package dependency.
module gl3_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [Width-1:0]           data_i,
  input  logic                       pop_i,
  output logic [Width-1:0]           data_o,
  output logic                       valid_o,
  output logic                       full_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int unsigned PtrBits = $clog2(Depth);
  localparam int unsigned CntBits = $clog2(Depth+1);

  logic [Width-1:0]   mem_q [Depth];
  logic [PtrBits-1:0] wptr_q, wptr_d;
  logic [PtrBits-1:0] rptr_q, rptr_d;
  logic [CntBits-1:0] count_q, count_d;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == CntBits'(Depth));
  assign data_o  = mem_q[rptr_q];
  assign count_o = count_q;

  always_comb begin
    wptr_d  = push_i ? wptr_q + 1'b1 : wptr_q;
    rptr_d  = pop_i ? rptr_q + 1'b1 : rptr_q;
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/core/gl3_front.sv =====
// Front end: configuration registers, input handshake, row/column counters
// and border classification of each item. Depends on gl3_pkg.
module gl3_front #(
  parameter int unsigned MaxWidth  = gl3_pkg::MaxWidthDefault,
  parameter int unsigned PixelBits = gl3_pkg::PixelBitsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_index_i,
  input  logic [gl3_pkg::CfgDataBits-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             operation_i,
  input  logic signed [PixelBits-1:0]      pixel_in_i,
  input  logic                             queue_full_i,
  output logic                             push_o,
  output logic signed [PixelBits-1:0]      item_pixel_o,
  output logic [$clog2(MaxWidth)-1:0]      item_col_o,
  output gl3_pkg::cls_t                    item_cls_o,
  output logic                             restart_o
);

  import gl3_pkg::*;

  localparam int unsigned ColBits = $clog2(MaxWidth);
  localparam int unsigned RowBits = HeightRegBits + 1;

  logic [WidthRegBits-1:0]  width_q;
  logic [HeightRegBits-1:0] height_q;
  logic [ColBits-1:0]       col_q, col_d;
  logic [RowBits-1:0]       row_q, row_d;
  logic [ColBits-1:0]       w_m1;
  logic [RowBits-1:0]       h_eff, h_p1;
  logic                     accept, first_col;
  cls_t                     cls;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = queue_full_i;
  assign push_o     = accept;
  assign restart_o  = cfg_we_i;

  // effective frame size: width clamped to 1..MaxWidth, height 0 acts as 1
  always_comb begin
    if (width_q == '0) begin
      w_m1 = '0;
    end else if (32'(width_q) > MaxWidth) begin
      w_m1 = ColBits'(MaxWidth - 1);
    end else begin
      w_m1 = ColBits'(width_q - 1'b1);
    end
    h_eff = (height_q == '0) ? RowBits'(1) : {1'b0, height_q};
    h_p1  = h_eff + 1'b1;
  end

  assign first_col = (col_q == '0);

  // column 0 finishes the last pixel of the row two rows up
  always_comb begin
    cls.emit       = first_col ? (row_q >= RowBits'(2)) : (row_q != '0);
    cls.mask_left  = first_col ? (w_m1 == '0) : (col_q == ColBits'(1));
    cls.mask_top   = first_col ? (row_q == RowBits'(2)) : (row_q == RowBits'(1));
    cls.mask_bot   = first_col ? (row_q >= h_p1) : (row_q >= h_eff);
    cls.right_zero = first_col;
    cls.last       = first_col && (row_q == h_p1);
  end

  assign item_cls_o   = cls;
  assign item_col_o   = col_q;
  assign item_pixel_o = (operation_i == OpPixel && row_q < h_eff) ? pixel_in_i : '0;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_we_i) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (cls.last) begin
        col_d = '0;
        row_d = '0;
      end else if (col_q == w_m1) begin
        col_d = '0;
        row_d = row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgImageWidth:  width_q  <= cfg_data_i[WidthRegBits-1:0];
          CfgImageHeight: height_q <= cfg_data_i[HeightRegBits-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== rtl/core/gl3_back.sv =====
// Back end: line stores, 3x3 window, weighted sum and divide by 160.
// Pops classified items from the item queue; depends on gl3_pkg.
module gl3_back #(
  parameter int unsigned MaxWidth  = gl3_pkg::MaxWidthDefault,
  parameter int unsigned PixelBits = gl3_pkg::PixelBitsDefault
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       restart_i,
  input  logic                                       item_valid_i,
  input  logic signed [PixelBits-1:0]                item_pixel_i,
  input  logic [$clog2(MaxWidth)-1:0]                item_col_i,
  input  gl3_pkg::cls_t                              item_cls_i,
  output logic                                       item_pop_o,
  input  logic [$clog2(gl3_pkg::OutQueueDepth+1)-1:0] out_count_i,
  output logic                                       res_push_o,
  output gl3_pkg::result_t                           res_o
);

  import gl3_pkg::*;

  localparam int unsigned ColBits    = $clog2(MaxWidth);
  localparam int unsigned CntBits    = $clog2(OutQueueDepth + 1);
  localparam int unsigned SumBits    = PixelBits + 4;
  localparam int unsigned MagBits    = SumBits - KernelShift;
  localparam int unsigned RecipShift = MagBits + 2;
  localparam logic [63:0] RecipWide  = ((64'd1 << RecipShift) + 64'd4) / 64'(KernelOdd);
  localparam logic [MagBits-1:0] Recip = RecipWide[MagBits-1:0];
  localparam int unsigned ProdBits   = 2 * MagBits;
  localparam int unsigned QmBits     = ProdBits - RecipShift;
  localparam int unsigned QBits      = (QmBits + 1 > OutBits) ? QmBits + 1 : OutBits;

  logic signed [PixelBits-1:0] line_a [0:MaxWidth-1];
  logic signed [PixelBits-1:0] line_b [0:MaxWidth-1];
  logic signed [PixelBits-1:0] rd_a_q, rd_b_q, fwd_a_q, fwd_b_q;
  logic                        fwd_q;

  logic                        s1_valid_q;
  logic signed [PixelBits-1:0] s1_pixel_q;
  logic [ColBits-1:0]          s1_col_q;
  cls_t                        s1_cls_q;

  // [0..2] newer column top..bottom, [3..5] older column
  logic signed [PixelBits-1:0] win_q [6];

  logic signed [PixelBits-1:0] a_cur, b_cur;
  logic signed [SumBits-1:0]   tap [9];
  logic signed [SumBits-1:0]   sum_d;

  logic                        s2_valid_q, s2_last_q;
  logic signed [SumBits-1:0]   s2_sum_q;
  logic [SumBits-1:0]          mag;
  logic [ProdBits-1:0]         prod_d;

  logic                        s3_valid_q, s3_last_q, s3_neg_q;
  logic [ProdBits-1:0]         s3_prod_q;
  logic [QBits-1:0]            q_ext, q_val;

  logic [CntBits:0]            credit_used;

  // pop only while the result queue can take every item in flight
  assign credit_used = {1'b0, out_count_i} + (CntBits+1)'(s1_valid_q)
                     + (CntBits+1)'(s2_valid_q) + (CntBits+1)'(s3_valid_q);
  assign item_pop_o  = item_valid_i && (credit_used < (CntBits+1)'(OutQueueDepth));

  // an item writing the column being read this cycle is forwarded
  assign a_cur = fwd_q ? fwd_a_q : rd_a_q;
  assign b_cur = fwd_q ? fwd_b_q : rd_b_q;

  always_ff @(posedge clk_i) begin
    rd_a_q  <= line_a[item_col_i];
    rd_b_q  <= line_b[item_col_i];
    fwd_a_q <= s1_pixel_q;
    fwd_b_q <= a_cur;
    if (s1_valid_q) begin
      line_a[s1_col_q] <= s1_pixel_q;
      line_b[s1_col_q] <= a_cur;
    end
  end

  always_comb begin
    tap[0] = (s1_cls_q.mask_left || s1_cls_q.mask_top) ? '0 : SumBits'(win_q[3]);
    tap[1] = s1_cls_q.mask_left ? '0 : SumBits'(win_q[4]);
    tap[2] = (s1_cls_q.mask_left || s1_cls_q.mask_bot) ? '0 : SumBits'(win_q[5]);
    tap[3] = s1_cls_q.mask_top ? '0 : SumBits'(win_q[0]);
    tap[4] = SumBits'(win_q[1]);
    tap[5] = s1_cls_q.mask_bot ? '0 : SumBits'(win_q[2]);
    tap[6] = (s1_cls_q.right_zero || s1_cls_q.mask_top) ? '0 : SumBits'(b_cur);
    tap[7] = s1_cls_q.right_zero ? '0 : SumBits'(a_cur);
    tap[8] = (s1_cls_q.right_zero || s1_cls_q.mask_bot) ? '0 : SumBits'(s1_pixel_q);
    sum_d  = tap[0] + tap[2] + tap[6] + tap[8]
           + ((tap[1] + tap[3] + tap[5] + tap[7]) <<< 1)
           + (tap[4] <<< 2);
  end

  // truncating divide: |sum| >> 5, then times reciprocal of 5
  assign mag    = s2_sum_q[SumBits-1] ? SumBits'(-s2_sum_q) : SumBits'(s2_sum_q);
  assign prod_d = ProdBits'(mag[SumBits-1:KernelShift]) * ProdBits'(Recip);

  assign q_ext = QBits'(s3_prod_q[ProdBits-1:RecipShift]);
  assign q_val = s3_neg_q ? (~q_ext + 1'b1) : q_ext;

  assign res_push_o = s3_valid_q;
  assign res_o.pixel = q_val[OutBits-1:0];
  assign res_o.last  = s3_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q      <= 1'b0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      fwd_q      <= s1_valid_q && (s1_col_q == item_col_i);
      s1_valid_q <= item_pop_o;
      s2_valid_q <= s1_valid_q && s1_cls_q.emit;
      s3_valid_q <= s2_valid_q;
      if (restart_i || (s1_valid_q && s1_cls_q.last)) begin
        for (int i = 0; i < 6; i++) begin
          win_q[i] <= '0;
        end
      end else if (s1_valid_q) begin
        win_q[3] <= win_q[0];
        win_q[4] <= win_q[1];
        win_q[5] <= win_q[2];
        win_q[0] <= b_cur;
        win_q[1] <= a_cur;
        win_q[2] <= s1_pixel_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_pixel_q <= item_pixel_i;
    s1_col_q   <= item_col_i;
    s1_cls_q   <= item_cls_i;
    s2_sum_q   <= sum_d;
    s2_last_q  <= s1_cls_q.last;
    s3_prod_q  <= prod_d;
    s3_neg_q   <= s2_sum_q[SumBits-1];
    s3_last_q  <= s2_last_q;
  end

endmodule

// ===== rtl/core/gaussian_3x3_lowpass_filter_unit.sv =====
// Top level of the 3x3 Gaussian low-pass filter: front end, item queue,
// back end and result queue. Depends on gl3_pkg, gl3_front, gl3_fifo, gl3_back.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o): one item per accept, either a
//    raster-order pixel (operation_i = pixel) or a flush tick. After the
//    last pixel of a frame send width+1 flush items to drain the last row.
//  - Output channel (out_valid_o / out_stall_i): one filtered pixel per
//    result; frame_last_o marks the last pixel of the frame.
//  - The result for a pixel comes with the item accepted width+1 items later.
//  - Throughput: one item per cycle while the result queue has room, set by
//    the line stores' single read port and single write port; the window,
//    sum and reciprocal divide are pipelined over three back-end stages.
//  - Config writes (cfg_we_i) are for the user to make only while the block
//    is idle; the block does not enforce it. Any write restarts the stream.
//    Reset sets width 640, height 480, empty queues.
//  - When the receiver stalls, results collect in an 8-entry queue; the back
//    end stops popping once it and results in flight would fill it, the 4-entry
//    item queue fills and in_stall_o rises. No item or result is dropped.
module gaussian_3x3_lowpass_filter_unit #(
  parameter int unsigned MaxWidth  = gl3_pkg::MaxWidthDefault,
  parameter int unsigned PixelBits = gl3_pkg::PixelBitsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_index_i,
  input  logic [gl3_pkg::CfgDataBits-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             operation_i,
  input  logic signed [PixelBits-1:0]      pixel_in_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [gl3_pkg::OutBits-1:0] pixel_out_o,
  output logic                             frame_last_o
);

  import gl3_pkg::*;

  localparam int unsigned ColBits  = $clog2(MaxWidth);
  localparam int unsigned ItemBits = PixelBits + ColBits + $bits(cls_t);
  localparam int unsigned ResBits  = $bits(result_t);

  logic                        push, restart;
  logic signed [PixelBits-1:0] f_pixel, q_pixel;
  logic [ColBits-1:0]          f_col, q_col;
  cls_t                        f_cls, q_cls;
  logic [ItemBits-1:0]         q_data;
  logic                        item_valid, item_full, item_pop;
  logic [$clog2(ItemQueueDepth+1)-1:0] item_count;

  logic                        res_push, out_full, out_pop;
  result_t                     res, out_res;
  logic [$clog2(OutQueueDepth+1)-1:0] out_count;

  gl3_front #(
    .MaxWidth (MaxWidth),
    .PixelBits(PixelBits)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .pixel_in_i  (pixel_in_i),
    .queue_full_i(item_full),
    .push_o      (push),
    .item_pixel_o(f_pixel),
    .item_col_o  (f_col),
    .item_cls_o  (f_cls),
    .restart_o   (restart)
  );

  gl3_fifo #(
    .Width(ItemBits),
    .Depth(ItemQueueDepth)
  ) u_item_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i ({f_pixel, f_col, f_cls}),
    .pop_i  (item_pop),
    .data_o (q_data),
    .valid_o(item_valid),
    .full_o (item_full),
    .count_o(item_count)
  );

  assign {q_pixel, q_col, q_cls} = q_data;

  gl3_back #(
    .MaxWidth (MaxWidth),
    .PixelBits(PixelBits)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (restart),
    .item_valid_i(item_valid),
    .item_pixel_i(q_pixel),
    .item_col_i  (q_col),
    .item_cls_i  (q_cls),
    .item_pop_o  (item_pop),
    .out_count_i (out_count),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  gl3_fifo #(
    .Width(ResBits),
    .Depth(OutQueueDepth)
  ) u_out_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res),
    .pop_i  (out_pop),
    .data_o (out_res),
    .valid_o(out_valid_o),
    .full_o (out_full),
    .count_o(out_count)
  );

  assign out_pop      = out_valid_o && !out_stall_i;
  assign pixel_out_o  = out_res.pixel;
  assign frame_last_o = out_res.last;

  // back-end credit must keep the result queue from overflowing
  a_out_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> (!out_full || out_pop))
    else $error("result pushed into a full result queue");

  a_pop_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop |-> item_valid)
    else $error("back end popped an empty item queue");

  a_accept_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (item_valid && item_count != '0))
    else $error("accepted item missing from item queue");

endmodule
